// ===== sv/orcf_pkg.sv =====
`timescale 1ns / 1ps
package orcf_pkg;

  localparam int IdCapacity = 8;

  typedef enum logic [3:0] {
    CMD_ARM       = 4'd0,
    CMD_PUBLISH   = 4'd1,
    CMD_CLR_EXACT = 4'd2,
    CMD_CLR_UNRDY = 4'd3,
    CMD_CLR_SIDE  = 4'd4,
    CMD_TAKE      = 4'd5,
    CMD_FINALIZE  = 4'd6,
    CMD_DROP_INFL = 4'd7,
    CMD_CLR_ALL   = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    RK_NOCHANGE = 3'd0,
    RK_ARM      = 3'd1,
    RK_PUBLISH  = 3'd2,
    RK_DECISION = 3'd3,
    RK_DROP     = 3'd4,
    RK_TAKEN    = 3'd5,
    RK_ERROR    = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ARMED = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  localparam logic [3:0] ReasonSuperseded = 4'd1;

  // Datapath to controller: how many results the request gives.
  typedef struct packed {
    logic two;      // two results
  } dp_status_t;

  // Controller to datapath.
  typedef struct packed {
    logic eval;     // latch request and evaluate
    logic emit;     // produce result number sel into the output register
    logic sel;      // 0 first result, 1 second
    logic commit;   // update state
  } dp_cmd_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== sv/orcf_datapath.sv =====
`timescale 1ns / 1ps
module orcf_datapath #(
  parameter int ID_CAPACITY = orcf_pkg::IdCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                enabled,
  input  orcf_pkg::dp_cmd_t   ctl,
  output orcf_pkg::dp_status_t sts,
  input  logic [3:0]          command,
  input  logic                side,
  input  logic [63:0]         order_id_bytes,
  input  logic [3:0]          order_id_length,
  input  logic [63:0]         generation_in,
  input  logic [63:0]         time_stamp,
  input  logic                post_ok,
  input  logic [3:0]          reason_code,
  output logic [2:0]          result_kind,
  output logic [63:0]         event_number,
  output logic                side_out,
  output logic [63:0]         generation_out,
  output logic [63:0]         order_id_out,
  output logic [3:0]          order_id_length_out,
  output logic [63:0]         armed_time,
  output logic [63:0]         visible_time,
  output logic [62:0]         decision_latency,
  output logic [3:0]          reason_out,
  output logic                accepted
);
  import orcf_pkg::*;

  localparam logic [3:0] CapLen = 4'(ID_CAPACITY);
  localparam logic [62:0] Max63 = '1;

  // Per-side state.
  logic [63:0] gen_ctr [2];
  phase_t      p_ph    [2];
  logic [63:0] p_id    [2];
  logic [3:0]  p_len   [2];
  logic [63:0] p_gen   [2];
  logic [63:0] p_arm   [2];
  logic [63:0] p_vis   [2];
  logic        f_act   [2];
  logic [63:0] f_id    [2];
  logic [3:0]  f_len   [2];
  logic [63:0] f_gen   [2];
  logic [63:0] f_arm   [2];
  logic [63:0] f_vis   [2];
  logic [63:0] ev_ctr;

  // Latched request and its decoded plan.
  logic [3:0]  r_cmd;
  logic        r_side;
  logic [63:0] r_bytes;
  logic [3:0]  r_len;
  logic [63:0] r_gen;
  logic [63:0] r_ts;
  logic [3:0]  r_reason;
  logic        r_enabled;
  logic        r_post;

  // Plan: up to two results; each result has a kind, side, source slot.
  logic [1:0]  n_res;       // 0 means single no-change or error
  logic        is_err;
  kind_t       k0, k1;
  logic        s0, s1;
  logic        src_f;       // result 0 from in-flight slot
  logic [3:0]  rs0, rs1;

  logic        match_s;
  logic [63:0] sub;

  always_comb begin
    match_s = (r_len == p_len[r_side]) &&
              (((r_bytes ^ p_id[r_side]) & byte_mask(r_len)) == '0);
  end

  always_comb begin
    logic rej;
    logic ts_pos;
    logic ts_lt;
    logic gen_bad;
    logic tk0, tk1;
    n_res = 2'd0; is_err = 1'b0;
    k0 = RK_NOCHANGE; k1 = RK_NOCHANGE;
    s0 = r_side; s1 = r_side; src_f = 1'b0;
    rs0 = '0; rs1 = '0;
    ts_pos = !r_ts[63] && (r_ts != '0);
    ts_lt = $signed(r_ts) < $signed(p_arm[r_side]);
    gen_bad = (r_gen != '0) && (p_gen[r_side] != r_gen);
    tk0 = (p_ph[0] == PH_READY) && !f_act[0];
    tk1 = (p_ph[1] == PH_READY) && !f_act[1];
    rej = 1'b0;
    case (r_cmd)
      CMD_ARM: begin
        if (!r_enabled || !r_post) begin
          n_res = 2'd0;
        end else if (!ts_pos || gen_ctr[r_side] == '1 || r_len == '0 ||
                     r_len > CapLen) begin
          is_err = 1'b1;
        end else if (p_ph[r_side] != PH_EMPTY) begin
          n_res = 2'd2; k0 = RK_DROP; rs0 = ReasonSuperseded; k1 = RK_ARM;
        end else begin
          n_res = 2'd1; k0 = RK_ARM;
        end
      end
      CMD_PUBLISH: begin
        if (r_enabled && p_ph[r_side] == PH_ARMED && match_s && !gen_bad &&
            !ts_lt) begin
          n_res = 2'd1; k0 = RK_PUBLISH;
        end
      end
      CMD_CLR_EXACT, CMD_CLR_UNRDY: begin
        if (r_cmd == CMD_CLR_UNRDY) begin
          rej = (r_gen == '0) || (p_ph[r_side] != PH_ARMED);
        end else begin
          rej = ts_pos && ts_lt;
        end
        if (p_ph[r_side] != PH_EMPTY && match_s && !gen_bad && !rej) begin
          n_res = 2'd1; k0 = RK_DROP; rs0 = r_reason;
        end
      end
      CMD_CLR_SIDE: begin
        if (p_ph[r_side] != PH_EMPTY) begin
          n_res = 2'd1; k0 = RK_DROP; rs0 = r_reason;
        end
      end
      CMD_TAKE: begin
        if (r_enabled) begin
          k0 = RK_TAKEN; k1 = RK_TAKEN;
          s0 = !tk0; s1 = 1'b1;
          n_res = 2'(tk0) + 2'(tk1);
        end
      end
      CMD_FINALIZE, CMD_DROP_INFL: begin
        if (f_act[r_side] && f_gen[r_side] == r_gen) begin
          n_res = 2'd1; src_f = 1'b1;
          if (r_cmd == CMD_FINALIZE) begin
            k0 = RK_DECISION;
          end else begin
            k0 = RK_DROP; rs0 = r_reason;
          end
        end
      end
      CMD_CLR_ALL: begin
        k0 = RK_DROP; k1 = RK_DROP; rs0 = r_reason; rs1 = r_reason;
        s0 = (p_ph[0] == PH_EMPTY); s1 = 1'b1;
        n_res = 2'((p_ph[0] != PH_EMPTY)) + 2'((p_ph[1] != PH_EMPTY));
      end
      default: is_err = 1'b1;
    endcase
  end

  // Latency: decision start minus visible time, used when the result is formed.
  assign sub = r_ts - f_vis[r_side];
  assign sts.two = (n_res == 2'd2);

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      r_cmd <= command; r_side <= side; r_bytes <= order_id_bytes;
      r_len <= order_id_length; r_gen <= generation_in; r_ts <= time_stamp;
      r_reason <= reason_code; r_enabled <= enabled; r_post <= post_ok;
    end
  end

  // Output register: one result per emit.
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      logic  s;
      kind_t k;
      logic  numbered;
      logic  arm_now;
      s = ctl.sel ? s1 : s0;
      k = ctl.sel ? k1 : k0;
      arm_now = (k == RK_ARM);
      numbered = (k != RK_TAKEN);
      if (n_res == 2'd0) begin
        result_kind <= is_err ? RK_ERROR : RK_NOCHANGE;
        event_number <= '0; side_out <= 1'b0; generation_out <= '0;
        order_id_out <= '0; order_id_length_out <= '0; armed_time <= '0;
        visible_time <= '0; decision_latency <= '0; reason_out <= '0;
        accepted <= 1'b0;
      end else begin
        result_kind <= k;
        // The second of two numbered results takes the number after the first.
        event_number <= numbered ? ev_ctr + (ctl.sel ? 64'd2 : 64'd1) : '0;
        side_out <= s;
        accepted <= 1'b1;
        reason_out <= ctl.sel ? rs1 : rs0;
        decision_latency <= '0;
        if (arm_now) begin
          generation_out <= gen_ctr[s] + 64'd1;
          order_id_out <= r_bytes & byte_mask(r_len);
          order_id_length_out <= r_len;
          armed_time <= r_ts;
          visible_time <= '0;
        end else if (src_f) begin
          generation_out <= f_gen[s];
          order_id_out <= f_id[s] & byte_mask(f_len[s]);
          order_id_length_out <= f_len[s];
          armed_time <= f_arm[s];
          visible_time <= f_vis[s];
          if (k == RK_DECISION && $signed(r_ts) > $signed(f_vis[s])) begin
            decision_latency <= sub[63] ? Max63 : sub[62:0];
          end
        end else begin
          generation_out <= p_gen[s];
          order_id_out <= p_id[s] & byte_mask(p_len[s]);
          order_id_length_out <= p_len[s];
          armed_time <= p_arm[s];
          visible_time <= (k == RK_PUBLISH) ? r_ts : p_vis[s];
        end
      end
    end
  end

  // State update, applied once per request that has results, at the edge that forms its last result.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_ctr <= '0;
      for (int i = 0; i < 2; i++) begin
        gen_ctr[i] <= '0; p_ph[i] <= PH_EMPTY; p_len[i] <= '0;
        p_gen[i] <= '0; p_arm[i] <= '0; p_vis[i] <= '0;
        f_act[i] <= 1'b0; f_len[i] <= '0; f_gen[i] <= '0;
        f_arm[i] <= '0; f_vis[i] <= '0;
      end
    end else if (ctl.commit && n_res != 2'd0) begin
      case (r_cmd)
        CMD_ARM: begin
          ev_ctr <= ev_ctr + 64'(n_res);
          gen_ctr[r_side] <= gen_ctr[r_side] + 64'd1;
          p_ph[r_side] <= PH_ARMED;
          p_id[r_side] <= r_bytes & byte_mask(r_len);
          p_len[r_side] <= r_len;
          p_gen[r_side] <= gen_ctr[r_side] + 64'd1;
          p_arm[r_side] <= r_ts;
          p_vis[r_side] <= '0;
        end
        CMD_PUBLISH: begin
          ev_ctr <= ev_ctr + 64'd1;
          p_vis[r_side] <= r_ts;
          p_ph[r_side] <= PH_READY;
        end
        CMD_TAKE: begin
          for (int i = 0; i < 2; i++) begin
            if (p_ph[i] == PH_READY && !f_act[i]) begin
              f_act[i] <= 1'b1; f_id[i] <= p_id[i]; f_len[i] <= p_len[i];
              f_gen[i] <= p_gen[i]; f_arm[i] <= p_arm[i];
              f_vis[i] <= p_vis[i];
              p_ph[i] <= PH_EMPTY; p_len[i] <= '0; p_gen[i] <= '0;
              p_arm[i] <= '0; p_vis[i] <= '0;
            end
          end
        end
        CMD_FINALIZE, CMD_DROP_INFL: begin
          ev_ctr <= ev_ctr + 64'd1;
          f_act[r_side] <= 1'b0; f_len[r_side] <= '0; f_gen[r_side] <= '0;
          f_arm[r_side] <= '0; f_vis[r_side] <= '0;
        end
        CMD_CLR_ALL: begin
          ev_ctr <= ev_ctr + 64'(n_res);
          for (int i = 0; i < 2; i++) begin
            p_ph[i] <= PH_EMPTY; p_len[i] <= '0; p_gen[i] <= '0;
            p_arm[i] <= '0; p_vis[i] <= '0;
          end
        end
        default: begin
          // Clear exact, clear unready and clear side drop the pending slot.
          ev_ctr <= ev_ctr + 64'd1;
          p_ph[r_side] <= PH_EMPTY; p_len[r_side] <= '0; p_gen[r_side] <= '0;
          p_arm[r_side] <= '0; p_vis[r_side] <= '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/orcf_ctrl.sv =====
`timescale 1ns / 1ps
module orcf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 last_result,
  input  orcf_pkg::dp_status_t sts,
  output orcf_pkg::dp_cmd_t    ctl
);
  import orcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_OUT0, S_OUT1
  } state_t;

  state_t state;
  logic   two;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.eval = (state == S_IDLE) && in_valid;
    ctl.emit = (state == S_EVAL) ||
               (state == S_OUT0 && out_ready && two);
    ctl.sel = (state == S_OUT0);
    ctl.commit = (state == S_OUT0 && out_ready && two) ||
                 (state == S_EVAL && !sts.two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; last_result <= 1'b0; two <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_EVAL;
        S_EVAL: begin
          two <= sts.two;
          out_valid <= 1'b1;
          last_result <= !sts.two;
          state <= S_OUT0;
        end
        S_OUT0: begin
          if (out_ready) begin
            if (two) begin
              last_result <= 1'b1;
              two <= 1'b0;
            end else begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("accepting while a result waits");
  a_last_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> !out_valid)
    else $error("result after the last one");
  a_valid_after_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("no result after request");

endmodule

// ===== sv/order_replace_continuation_fsm.sv =====
`timescale 1ns / 1ps
// The controller accepts a request in idle, passes through its evaluate state,
// then offers the results one at a time from the output register, each held
// until out_ready; no new request is accepted until the last one is taken.
// Reset (rst, synchronous, high) empties both sides, zeroes the counters
// and sets enabled to 1.
module order_replace_continuation_fsm #(
  parameter int ID_CAPACITY = orcf_pkg::IdCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic        side,
  input  logic [63:0] order_id_bytes,
  input  logic [3:0]  order_id_length,
  input  logic [63:0] generation_in,
  input  logic [63:0] time_stamp,
  input  logic        post_ok,
  input  logic [3:0]  reason_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [63:0] event_number,
  output logic        side_out,
  output logic [63:0] generation_out,
  output logic [63:0] order_id_out,
  output logic [3:0]  order_id_length_out,
  output logic [63:0] armed_time,
  output logic [63:0] visible_time,
  output logic [62:0] decision_latency,
  output logic [3:0]  reason_out,
  output logic        accepted,
  output logic        last_result
);
  import orcf_pkg::*;

  logic         enabled;
  dp_cmd_t      ctl;
  dp_status_t   sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) enabled <= 1'b1;
    else if (cfg_valid) enabled <= cfg_data;
  end

  orcf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .last_result,
    .sts, .ctl
  );

  orcf_datapath #(.ID_CAPACITY(ID_CAPACITY)) u_dp (
    .clk, .rst, .enabled, .ctl, .sts, .command, .side, .order_id_bytes,
    .order_id_length, .generation_in, .time_stamp, .post_ok, .reason_code,
    .result_kind, .event_number, .side_out, .generation_out, .order_id_out,
    .order_id_length_out, .armed_time, .visible_time, .decision_latency,
    .reason_out, .accepted
  );

endmodule

// ===== tb/sv/order_replace_continuation_fsm_tb.sv =====
`timescale 1ns / 1ps
module order_replace_continuation_fsm_tb;
  import orcf_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [3:0]  command;
    logic        side;
    logic [63:0] id_bytes;
    logic [3:0]  id_len;
    logic [63:0] gen;
    logic [63:0] ts;
    logic        post_ok;
    logic [3:0]  reason;
  } request_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] evt;
    logic        side;
    logic [63:0] gen;
    logic [63:0] id;
    logic [3:0]  len;
    logic [63:0] armed;
    logic [63:0] vis;
    logic [62:0] lat;
    logic [3:0]  reason;
    logic        acc;
    logic        last;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0, cfg_data = 0;
  logic in_valid = 0;
  logic out_ready = 0;
  request_t req_q = '0;
  logic cfg_ready, in_ready, out_valid;
  result_t got;

  always #1 clk = ~clk;

  order_replace_continuation_fsm dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(req_q.command), .side(req_q.side), .order_id_bytes(req_q.id_bytes),
    .order_id_length(req_q.id_len), .generation_in(req_q.gen),
    .time_stamp(req_q.ts), .post_ok(req_q.post_ok), .reason_code(req_q.reason),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(got.kind), .event_number(got.evt), .side_out(got.side),
    .generation_out(got.gen), .order_id_out(got.id),
    .order_id_length_out(got.len), .armed_time(got.armed),
    .visible_time(got.vis), .decision_latency(got.lat),
    .reason_out(got.reason), .accepted(got.acc), .last_result(got.last)
  );

  // Shadow copy of the block state.
  bit          en;
  logic [63:0] gen_ctr [2];
  phase_t      ph [2];
  logic [63:0] p_id [2], p_gen [2], p_armed [2], p_vis [2];
  logic [3:0]  p_len [2];
  bit          f_act [2];
  logic [63:0] f_id [2], f_gen [2], f_armed [2], f_vis [2];
  logic [3:0]  f_len [2];
  logic [63:0] evt_ctr;

  result_t expected_results[$];
  bit failed = 0;
  int cycles = 0;
  int out_gap = 0;

  function automatic logic [63:0] id_mask(logic [3:0] len);
    return (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 1);
  endfunction

  function automatic bit same_id(int s, logic [63:0] b, logic [3:0] len);
    return len == p_len[s] && ((b ^ p_id[s]) & id_mask(len)) == 0;
  endfunction

  function automatic result_t make_result(logic [2:0] kind, bit numbered, int s,
      logic [63:0] g, logic [63:0] id, logic [3:0] len, logic [63:0] armed,
      logic [63:0] vis, logic [62:0] lat, logic [3:0] reason);
    result_t r;
    r = '0;
    r.kind = kind;
    if (numbered) begin
      evt_ctr++;
      r.evt = evt_ctr;
    end
    r.side = s[0];
    r.gen = g;
    r.id = id & id_mask(len);
    r.len = len;
    r.armed = armed;
    r.vis = vis;
    r.lat = lat;
    r.reason = reason;
    r.acc = 1'b1;
    return r;
  endfunction

  function automatic result_t pending_result(logic [2:0] kind, int s,
      logic [3:0] reason, bit numbered);
    return make_result(kind, numbered, s, p_gen[s], p_id[s], p_len[s], p_armed[s],
                       p_vis[s], '0, reason);
  endfunction

  function automatic void empty_pending(int s);
    ph[s] = PH_EMPTY;
    p_len[s] = '0; p_gen[s] = '0; p_armed[s] = '0; p_vis[s] = '0;
  endfunction

  function automatic void reset_state();
    en = 1'b1;
    evt_ctr = '0;
    for (int s = 0; s < 2; s++) begin
      gen_ctr[s] = '0; empty_pending(s); p_id[s] = '0;
      f_act[s] = 1'b0; f_id[s] = '0; f_len[s] = '0; f_gen[s] = '0;
      f_armed[s] = '0; f_vis[s] = '0;
    end
  endfunction

  // Returns the results of one request; with none, a single no-change result, or an error result if bad is set.
  function automatic void predict_request(request_t q, ref result_t rs[$]);
    int s;
    bit bad;
    bit unready;
    logic signed [63:0] ets;
    logic [63:0] lat;
    result_t r;
    s = int'(q.side);
    bad = 0;
    rs = {};
    case (q.command)
      CMD_ARM: begin
        if (en && q.post_ok) begin
          if ($signed(q.ts) <= 0 || gen_ctr[s] == '1 || q.id_len == 0 ||
              q.id_len > IdCapacity) bad = 1;
          else begin
            if (ph[s] != PH_EMPTY)
              rs = {rs, pending_result(RK_DROP, s, ReasonSuperseded, 1)};
            gen_ctr[s]++;
            ph[s] = PH_ARMED;
            p_id[s] = q.id_bytes & id_mask(q.id_len);
            p_len[s] = q.id_len;
            p_gen[s] = gen_ctr[s];
            p_armed[s] = q.ts;
            p_vis[s] = '0;
            rs = {rs, pending_result(RK_ARM, s, 4'd0, 1)};
          end
        end
      end
      CMD_PUBLISH: begin
        if (en && ph[s] == PH_ARMED && same_id(s, q.id_bytes, q.id_len) &&
            (q.gen == 0 || p_gen[s] == q.gen) &&
            $signed(q.ts) >= $signed(p_armed[s])) begin
          p_vis[s] = q.ts;
          ph[s] = PH_READY;
          rs = {rs, pending_result(RK_PUBLISH, s, 4'd0, 1)};
        end
      end
      CMD_CLR_EXACT, CMD_CLR_UNRDY: begin
        unready = q.command == CMD_CLR_UNRDY;
        ets = unready ? 64'sd0 : $signed(q.ts);
        if (!(ph[s] == PH_EMPTY || !same_id(s, q.id_bytes, q.id_len) ||
              (unready && q.gen == 0) || (q.gen != 0 && p_gen[s] != q.gen) ||
              (ets > 0 && ets < $signed(p_armed[s])) ||
              (unready && ph[s] != PH_ARMED))) begin
          rs = {rs, pending_result(RK_DROP, s, q.reason, 1)};
          empty_pending(s);
        end
      end
      CMD_CLR_SIDE: begin
        if (ph[s] != PH_EMPTY) begin
          rs = {rs, pending_result(RK_DROP, s, q.reason, 1)};
          empty_pending(s);
        end
      end
      CMD_TAKE: begin
        if (en) begin
          for (int t = 0; t < 2; t++) begin
            if (ph[t] == PH_READY && !f_act[t]) begin
              rs = {rs, pending_result(RK_TAKEN, t, 4'd0, 0)};
              f_act[t] = 1'b1; f_id[t] = p_id[t]; f_len[t] = p_len[t];
              f_gen[t] = p_gen[t]; f_armed[t] = p_armed[t]; f_vis[t] = p_vis[t];
              empty_pending(t);
            end
          end
        end
      end
      CMD_FINALIZE, CMD_DROP_INFL: begin
        if (f_act[s] && f_gen[s] == q.gen) begin
          lat = '0;
          if (q.command == CMD_FINALIZE && $signed(q.ts) > $signed(f_vis[s])) begin
            lat = q.ts - f_vis[s];
            if (lat[63]) lat = 64'h7fff_ffff_ffff_ffff;
          end
          rs = {rs, make_result(q.command == CMD_FINALIZE ? RK_DECISION : RK_DROP,
              1, s, f_gen[s], f_id[s], f_len[s], f_armed[s], f_vis[s], lat[62:0],
              q.command == CMD_FINALIZE ? 4'd0 : q.reason)};
          f_act[s] = 1'b0; f_len[s] = '0; f_gen[s] = '0; f_armed[s] = '0;
          f_vis[s] = '0;
        end
      end
      CMD_CLR_ALL: begin
        for (int t = 0; t < 2; t++) begin
          if (ph[t] != PH_EMPTY) begin
            rs = {rs, pending_result(RK_DROP, t, q.reason, 1)};
            empty_pending(t);
          end
        end
      end
      default: bad = 1;
    endcase
    if (rs.size() == 0) begin
      r = '0;
      r.kind = bad ? RK_ERROR : RK_NOCHANGE;
      rs = {rs, r};
    end
    rs[rs.size() - 1].last = 1'b1;
  endfunction

  // Valid stays high across back-to-back requests; it drops only before a gap.
  task automatic send_request(request_t q, bit typed, result_t want);
    result_t rs[$];
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_q <= q;
    do @(posedge clk); while (!in_ready);
    predict_request(q, rs);
    if (typed && rs[0] !== want) begin
      $error("directed row: kind expected %0d actual %0d (typed value)",
             want.kind, rs[0].kind);
      failed = 1;
    end
    foreach (rs[i]) expected_results = {expected_results, rs[i]};
  endtask

  task automatic write_enable(bit v);
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    en = v;
  endtask

  // Result side: a random stall before each result.
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d", got.kind);
          failed = 1;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (got.kind !== e.kind) begin
            $error("result_kind exp %0d act %0d", e.kind, got.kind); failed = 1;
          end
          if (got.evt !== e.evt) begin
            $error("event_number exp %0d act %0d", e.evt, got.evt); failed = 1;
          end
          if (got.side !== e.side) begin
            $error("side_out exp %0d act %0d", e.side, got.side); failed = 1;
          end
          if (got.gen !== e.gen) begin
            $error("generation_out exp %h act %h", e.gen, got.gen); failed = 1;
          end
          if (got.id !== e.id) begin
            $error("order_id_out exp %h act %h", e.id, got.id); failed = 1;
          end
          if (got.len !== e.len) begin
            $error("order_id_length_out exp %0d act %0d", e.len, got.len);
            failed = 1;
          end
          if (got.armed !== e.armed) begin
            $error("armed_time exp %h act %h", e.armed, got.armed); failed = 1;
          end
          if (got.vis !== e.vis) begin
            $error("visible_time exp %h act %h", e.vis, got.vis); failed = 1;
          end
          if (got.lat !== e.lat) begin
            $error("decision_latency exp %h act %h", e.lat, got.lat); failed = 1;
          end
          if (got.reason !== e.reason) begin
            $error("reason_out exp %0d act %0d", e.reason, got.reason); failed = 1;
          end
          if (got.acc !== e.acc) begin
            $error("accepted exp %0d act %0d", e.acc, got.acc); failed = 1;
          end
          if (got.last !== e.last) begin
            $error("last_result exp %0d act %0d", e.last, got.last); failed = 1;
          end
        end
        out_gap = $urandom_range(0, 3);
      end else if (out_valid && out_gap > 0) begin
        out_gap = out_gap - 1;
      end
      out_ready <= (out_gap == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("order_replace_continuation_fsm regression: fail");
      $finish;
    end
  end

  function automatic request_t mk(cmd_t c, bit s, logic [63:0] b, logic [3:0] len,
      logic [63:0] g, logic [63:0] ts, bit cp, logic [3:0] rc);
    request_t q;
    q.command = c; q.side = s; q.id_bytes = b; q.id_len = len; q.gen = g;
    q.ts = ts; q.post_ok = cp; q.reason = rc;
    return q;
  endfunction

  function automatic result_t plain(kind_t k);
    result_t r;
    r = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  // Random request, mostly following a live intent so that sequences go deep.
  function automatic request_t random_request();
    request_t q;
    int s;
    int pick;
    q.command = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 19) == 0) q.command = 4'($urandom_range(9, 15));
    s = int'($urandom_range(0, 1));
    q.side = s[0];
    q.id_bytes = {$urandom, $urandom};
    q.id_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 8));
    q.gen = '0;
    q.ts = 64'($urandom_range(1, 1000000));
    q.post_ok = $urandom_range(0, 7) != 0;
    q.reason = 4'($urandom);
    pick = int'($urandom_range(0, 9));
    if (q.command == CMD_ARM && pick == 0) q.ts = {$urandom, $urandom};
    if (q.command inside {CMD_PUBLISH, CMD_CLR_EXACT, CMD_CLR_UNRDY} && pick < 8) begin
      q.id_bytes = p_id[s] | (({$urandom, $urandom}) & ~id_mask(p_len[s]));
      q.id_len = p_len[s];
      q.gen = (pick < 3) ? 64'd0 : p_gen[s];
      if (q.command == CMD_PUBLISH) q.ts = p_armed[s] + 64'($urandom_range(0, 500));
      else if (pick == 7) q.ts = {$urandom, $urandom};
    end
    if (q.command inside {CMD_FINALIZE, CMD_DROP_INFL}) begin
      q.gen = (pick < 8) ? f_gen[s] : {$urandom, $urandom};
      q.ts = (pick == 9) ? {$urandom, $urandom}
                         : f_vis[s] + 64'($urandom_range(0, 3000)) - 64'd500;
    end
    if (q.command == 9) q.command = CMD_TAKE;
    return q;
  endfunction

  row_t rows[$];
  result_t none_r;

  initial begin
    reset_state();
    none_r = '0;
    rows = '{
      '{mk(CMD_TAKE, 0, 0, 0, 0, 0, 0, 0), 1, plain(RK_NOCHANGE)},
      '{mk(CMD_CLR_ALL, 1, 0, 0, 0, 0, 0, 3), 1, plain(RK_NOCHANGE)},
      '{mk(cmd_t'(4'd15), 1, '1, 15, '1, '1, 1, 15), 1, plain(RK_ERROR)},
      '{mk(cmd_t'(4'd9), 0, 0, 0, 0, 0, 0, 0), 1, plain(RK_ERROR)},
      '{mk(CMD_ARM, 0, '1, 8, 0, 100, 0, 0), 1, plain(RK_NOCHANGE)},
      '{mk(CMD_ARM, 0, '1, 8, 0, 0, 1, 0), 1, plain(RK_ERROR)},
      '{mk(CMD_ARM, 0, '1, 8, 0, 64'h8000_0000_0000_0000, 1, 0), 1, plain(RK_ERROR)},
      '{mk(CMD_ARM, 0, '1, 0, 0, 5, 1, 0), 1, plain(RK_ERROR)},
      '{mk(CMD_ARM, 0, '1, 9, 0, 5, 1, 0), 1, plain(RK_ERROR)},
      '{mk(CMD_ARM, 0, '1, 8, 0, 64'h7fff_ffff_ffff_ffff, 1, 0), 0, none_r},
      '{mk(CMD_ARM, 0, 64'h1122_3344_5566_7788, 3, 0, 10, 1, 0), 0, none_r},
      '{mk(CMD_PUBLISH, 0, 64'hffff_ffff_ff66_7788, 3, 2, 20, 0, 0), 0, none_r},
      '{mk(CMD_ARM, 1, 64'h00aa, 1, 0, 1, 1, 0), 0, none_r},
      '{mk(CMD_PUBLISH, 1, 64'h00aa, 1, 0, 64'h8000_0000_0000_0000, 0, 0), 0, none_r},
      '{mk(CMD_PUBLISH, 1, 64'h00aa, 1, 0, 64'h8000_0000_0000_0000, 0, 0), 0, none_r},
      '{mk(CMD_CLR_UNRDY, 1, 64'h00aa, 1, 0, 0, 0, 2), 0, none_r},
      '{mk(CMD_CLR_UNRDY, 1, 64'h00aa, 1, 1, 0, 0, 2), 0, none_r},
      '{mk(CMD_ARM, 1, 64'h00bb, 1, 0, 1, 1, 0), 0, none_r},
      '{mk(CMD_PUBLISH, 1, 64'h00bb, 1, 0, 64'hffff_ffff_ffff_ff00, 0, 0), 0, none_r},
      '{mk(CMD_TAKE, 1, 0, 0, 0, 0, 0, 0), 0, none_r},
      '{mk(CMD_FINALIZE, 0, 0, 0, 2, 64'h7fff_ffff_ffff_ffff, 0, 0), 0, none_r},
      '{mk(CMD_FINALIZE, 1, 0, 0, 2, 64'h7fff_ffff_ffff_ffff, 0, 0), 0, none_r},
      '{mk(CMD_ARM, 0, 64'h55, 2, 0, 7, 1, 0), 0, none_r},
      '{mk(CMD_CLR_EXACT, 0, 64'h55, 2, 0, 3, 0, 9), 0, none_r},
      '{mk(CMD_CLR_ALL, 0, 0, 0, 0, 0, 0, 15), 0, none_r}
    };
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].res);
    for (int phase = 0; phase < 4; phase++) begin
      write_enable(phase % 2 == 1 ? 1'b0 : 1'b1);
      for (int n = 0; n < (phase % 2 == 1 ? 150 : 500); n++)
        send_request(random_request(), 0, none_r);
    end
    write_enable(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) $display("order_replace_continuation_fsm regression: pass");
    else $display("order_replace_continuation_fsm regression: fail");
    $finish;
  end

endmodule
